// File: design/sphc_pkg.sv
// ----------------------------------------------------------------------------
// SCTP header check package
// Shared types, codes and the bytewise CRC32c update.
// ----------------------------------------------------------------------------
`default_nettype none

package sphc_pkg;

    localparam int unsigned BYTE_COUNT_W = 16;

    localparam logic [BYTE_COUNT_W-1:0] HDR_BYTES = 16'd12;
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // where a byte falls in the common header
    typedef enum logic [2:0] {
        KIND_SRC  = 3'd0,
        KIND_DST  = 3'd1,
        KIND_TAG  = 3'd2,
        KIND_CSUM = 3'd3,
        KIND_BODY = 3'd4
    } field_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TRUNCATED = 2'd1,
        STATUS_MISMATCH  = 2'd2,
        STATUS_TOO_LONG  = 2'd3
    } status_t;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0]              data_byte;
        logic                    last_byte;
        field_kind_t             kind;
        logic [1:0]              lane;      // checksum byte lane
        logic                    active;    // byte counts (length not yet overflowed)
        logic                    overflow;  // overflow flag after this byte
        logic [BYTE_COUNT_W-1:0] count;     // byte count after this byte
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // reflected CRC32c, one byte
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/sphc_front.sv
// ----------------------------------------------------------------------------
// SCTP header check front end
// Counts bytes, tracks overflow and tags each byte with its header field.
// ----------------------------------------------------------------------------
`default_nettype none

module sphc_front #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output sphc_pkg::entry_t       push_entry
);

    localparam logic [sphc_pkg::BYTE_COUNT_W-1:0] MAX_COUNT =
        sphc_pkg::BYTE_COUNT_W'(MAX_PACKET_BYTES);

    logic [sphc_pkg::BYTE_COUNT_W-1:0] count_reg, count_next, count_after;
    logic                              ovf_reg, ovf_next, ovf_after;
    logic                              accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        count_after = count_reg;
        ovf_after   = ovf_reg;
        if (!ovf_reg)
        begin
            if (count_reg >= MAX_COUNT)
                ovf_after = 1'b1;
            else
                count_after = count_reg + 16'd1;
        end
    end

    always_comb
    begin
        push_entry.data_byte = data_byte;
        push_entry.last_byte = last_byte;
        push_entry.lane      = count_reg[1:0];
        push_entry.active    = !ovf_reg;
        push_entry.overflow  = ovf_after;
        push_entry.count     = count_after;
        if (count_reg < 16'd2)
            push_entry.kind = sphc_pkg::KIND_SRC;
        else if (count_reg < 16'd4)
            push_entry.kind = sphc_pkg::KIND_DST;
        else if (count_reg < 16'd8)
            push_entry.kind = sphc_pkg::KIND_TAG;
        else if (count_reg < sphc_pkg::HDR_BYTES)
            push_entry.kind = sphc_pkg::KIND_CSUM;
        else
            push_entry.kind = sphc_pkg::KIND_BODY;
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_after;
                ovf_next   = ovf_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// File: design/sphc_queue.sv
// ----------------------------------------------------------------------------
// SCTP header check queue
// Small register FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sphc_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: design/sphc_back.sv
// ----------------------------------------------------------------------------
// SCTP header check back end
// Runs the CRC32c, captures header fields and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sphc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire sphc_pkg::entry_t  pop_entry,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [15:0]            src_port,
    output logic [15:0]            dst_port,
    output logic [31:0]            ver_tag,
    output logic [15:0]            chunk_area_length
);

    logic [31:0] crc_reg, crc_next, crc_upd;
    logic [15:0] src_reg, src_next;
    logic [15:0] dst_reg, dst_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] csum_reg, csum_next;
    logic [7:0]  crc_in;
    logic        do_pop;

    sphc_pkg::status_t res_status;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg;
    logic [15:0]       src_out_reg, dst_out_reg, len_out_reg;
    logic [31:0]       tag_out_reg;

    assign pop_ready = !out_valid_reg || out_ready;
    assign do_pop    = pop_valid && pop_ready;

    // checksum field enters the CRC as zero
    assign crc_in  = (pop_entry.kind == sphc_pkg::KIND_CSUM) ? 8'd0 : pop_entry.data_byte;
    assign crc_upd = sphc_pkg::crc32c_byte(crc_reg, crc_in);

    // state after this byte, before the end-of-packet clear
    always_comb
    begin
        crc_next  = crc_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        tag_next  = tag_reg;
        csum_next = csum_reg;
        if (pop_entry.active)
        begin
            crc_next = crc_upd;
            case (pop_entry.kind)
                sphc_pkg::KIND_SRC:  src_next = {src_reg[7:0], pop_entry.data_byte};
                sphc_pkg::KIND_DST:  dst_next = {dst_reg[7:0], pop_entry.data_byte};
                sphc_pkg::KIND_TAG:  tag_next = {tag_reg[23:0], pop_entry.data_byte};
                sphc_pkg::KIND_CSUM:
                begin
                    case (pop_entry.lane)
                        2'd0:    csum_next[7:0]   = csum_reg[7:0]   | pop_entry.data_byte;
                        2'd1:    csum_next[15:8]  = csum_reg[15:8]  | pop_entry.data_byte;
                        2'd2:    csum_next[23:16] = csum_reg[23:16] | pop_entry.data_byte;
                        default: csum_next[31:24] = csum_reg[31:24] | pop_entry.data_byte;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (pop_entry.overflow)
            res_status = sphc_pkg::STATUS_TOO_LONG;
        else if (pop_entry.count < sphc_pkg::HDR_BYTES)
            res_status = sphc_pkg::STATUS_TRUNCATED;
        else if (~crc_next != csum_next)
            res_status = sphc_pkg::STATUS_MISMATCH;
        else
            res_status = sphc_pkg::STATUS_OK;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (do_pop && pop_entry.last_byte)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= sphc_pkg::CRC_INIT;
            src_reg       <= '0;
            dst_reg       <= '0;
            tag_reg       <= '0;
            csum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (do_pop)
            begin
                if (pop_entry.last_byte)
                begin
                    crc_reg  <= sphc_pkg::CRC_INIT;
                    src_reg  <= '0;
                    dst_reg  <= '0;
                    tag_reg  <= '0;
                    csum_reg <= '0;
                end
                else
                begin
                    crc_reg  <= crc_next;
                    src_reg  <= src_next;
                    dst_reg  <= dst_next;
                    tag_reg  <= tag_next;
                    csum_reg <= csum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && pop_entry.last_byte)
        begin
            status_reg <= res_status;
            if (res_status == sphc_pkg::STATUS_OK)
            begin
                src_out_reg <= src_next;
                dst_out_reg <= dst_next;
                tag_out_reg <= tag_next;
                len_out_reg <= pop_entry.count - sphc_pkg::HDR_BYTES;
            end
            else
            begin
                src_out_reg <= '0;
                dst_out_reg <= '0;
                tag_out_reg <= '0;
                len_out_reg <= '0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign src_port          = src_out_reg;
    assign dst_port          = dst_out_reg;
    assign ver_tag           = tag_out_reg;
    assign chunk_area_length = len_out_reg;

endmodule

`default_nettype wire

// File: design/sctp_packet_header_check.sv
// ----------------------------------------------------------------------------
// SCTP packet header check
// Byte-stream checker for the SCTP common header and CRC32c.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one packet byte per transfer in wire
// order, last_byte set on the final byte. Output channel (out_valid/
// out_ready): one result transfer per packet, carrying status (ok,
// truncated, checksum mismatch, too long) and, when ok, source port,
// destination port, verification tag and chunk area length.
// Throughput: one byte per cycle, back to back, unless the receiver stalls. The
// front end counts and classifies bytes; a two-entry queue feeds the back end,
// which does one bytewise CRC32c update per cycle while it pops.
// out_valid is registered: the last byte is written to the queue, then popped
// into the output register, which raises out_valid.
// When the receiver stalls, the result waits in the output register and
// the back end stops popping at once; the queue fills, then in_ready drops.
// Reset: clears counts, CRC and all valid flags; no packet is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sctp_packet_header_check #(
    parameter int unsigned MAX_PACKET_BYTES = 65535,
    parameter int unsigned QUEUE_DEPTH      = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      src_port,
    output logic [15:0]      dst_port,
    output logic [31:0]      ver_tag,
    output logic [15:0]      chunk_area_length
);

    sphc_pkg::entry_t push_entry, pop_entry;
    logic             push_valid, push_ready;
    logic             pop_valid, pop_ready;
    logic [sphc_pkg::ENTRY_W-1:0] pop_bits;

    // classify each byte by position, track length
    sphc_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // decouples front from back so either side can stall
    sphc_queue #(
        .WIDTH (sphc_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_bits)
    );

    assign pop_entry = sphc_pkg::entry_t'(pop_bits);

    // CRC, field capture, result register
    sphc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_entry         (pop_entry),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .src_port          (src_port),
        .dst_port          (dst_port),
        .ver_tag           (ver_tag),
        .chunk_area_length (chunk_area_length)
    );

endmodule

`default_nettype wire
